// ===== rtl/core/double_ended_queue_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Deque assertion macros
// Shared concurrent assertion shorthands; they sample on clk and are
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");
`define DEQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");
`else
`define DEQ_ASSERT_IMP(lbl, ante, cons)
`define DEQ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/deq_pkg.sv =====
// ---------------------------------------------------------------------------
// Deque package
// Sizes, operation codes, status codes and ring arithmetic for the deque.
// ---------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int WORD_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 0,
    KIND_PUSH_BACK  = 1,
    KIND_POP_FRONT  = 2,
    KIND_POP_BACK   = 3,
    KIND_LIST_FWD   = 4,
    KIND_LIST_BWD   = 5
  } kind_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH_F,
    OP_PUSH_B,
    OP_POP_F,
    OP_POP_B,
    OP_LIST_F,
    OP_LIST_B
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 0,
    ST_EMPTY = 1,
    ST_FULL  = 2
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_LIST
  } back_state_t;

  typedef struct packed {
    op_t                     op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  // Ring position base + off, with base < DEPTH and off < DEPTH.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/core/deq_front.sv =====
// ---------------------------------------------------------------------------
// Deque front end
// Accepts requests, decodes the kind into an operation and holds them in a
// short command queue until the back end takes them.
// ---------------------------------------------------------------------------
module deq_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [deq_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [deq_pkg::WORD_W-1:0]  in_value_in,
  output logic                               cmd_valid,
  output deq_pkg::cmd_t                      cmd,
  input  logic                               cmd_pop
);

  deq_pkg::cmd_t                  q_r [deq_pkg::QDEPTH];
  logic [deq_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [deq_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [deq_pkg::QCNT_W-1:0]     fill_r, fill_nxt;
  deq_pkg::cmd_t                  dec;
  logic                           push;

  always_comb begin
    dec.value = in_value_in;
    case (deq_pkg::kind_t'(in_kind))
      deq_pkg::KIND_PUSH_FRONT: dec.op = deq_pkg::OP_PUSH_F;
      deq_pkg::KIND_PUSH_BACK:  dec.op = deq_pkg::OP_PUSH_B;
      deq_pkg::KIND_POP_FRONT:  dec.op = deq_pkg::OP_POP_F;
      deq_pkg::KIND_POP_BACK:   dec.op = deq_pkg::OP_POP_B;
      deq_pkg::KIND_LIST_FWD:   dec.op = deq_pkg::OP_LIST_F;
      deq_pkg::KIND_LIST_BWD:   dec.op = deq_pkg::OP_LIST_B;
      default:                  dec.op = deq_pkg::OP_NOP;
    endcase
  end

  assign in_stall  = (fill_r == deq_pkg::QCNT_W'(deq_pkg::QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == deq_pkg::QPTR_W'(deq_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + deq_pkg::QPTR_W'(1);
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == deq_pkg::QPTR_W'(deq_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + deq_pkg::QPTR_W'(1);
    end
    if (push && !cmd_pop) begin
      fill_nxt = fill_r + deq_pkg::QCNT_W'(1);
    end else if (!push && cmd_pop) begin
      fill_nxt = fill_r - deq_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== rtl/core/deq_back.sv =====
// ---------------------------------------------------------------------------
// Deque back end
// Executes queued operations on the ring buffer and drives the result
// register; a list walks the held entries one per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
module deq_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  input  deq_pkg::cmd_t                      cmd,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [deq_pkg::WORD_W-1:0]  out_value_out,
  output logic [deq_pkg::STATUS_W-1:0]       out_status,
  output logic [deq_pkg::COUNT_W-1:0]        out_count_out,
  output logic                               out_last
);

  logic signed [deq_pkg::WORD_W-1:0] store_r [deq_pkg::DEPTH];
  deq_pkg::back_state_t              state_r, state_nxt;
  logic [deq_pkg::IDX_W-1:0]         front_r, front_nxt;
  logic [deq_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [deq_pkg::CNT_W-1:0]         step_r, step_nxt;

  logic                              can_emit;
  logic                              emit;
  logic signed [deq_pkg::WORD_W-1:0] e_value;
  deq_pkg::status_t                  e_status;
  logic                              e_last;
  logic                              wr_en;
  logic [deq_pkg::IDX_W-1:0]         wr_idx;
  logic [deq_pkg::IDX_W-1:0]         rd_idx;
  logic [deq_pkg::CNT_W-1:0]         list_off;
  logic                              list_done;

  logic                              out_valid_r;
  logic signed [deq_pkg::WORD_W-1:0] value_r;
  deq_pkg::status_t                  status_r;
  logic [deq_pkg::COUNT_W-1:0]       count_out_r;
  logic                              last_r;

  assign can_emit  = !out_valid_r || !out_stall;
  assign list_off  = (cmd.op == deq_pkg::OP_LIST_F) ? step_r
                     : count_r - deq_pkg::CNT_W'(1) - step_r;
  assign list_done = (step_r + deq_pkg::CNT_W'(1) == count_r);

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    e_value   = '0;
    e_status  = deq_pkg::ST_OK;
    e_last    = 1'b1;
    wr_en     = 1'b0;
    wr_idx    = front_r;
    rd_idx    = front_r;
    case (state_r)
      deq_pkg::BK_IDLE: begin
        if (cmd_valid && can_emit) begin
          emit = 1'b1;
          case (cmd.op)
            deq_pkg::OP_PUSH_F, deq_pkg::OP_PUSH_B: begin
              cmd_pop = 1'b1;
              if (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH)) begin
                e_status = deq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + deq_pkg::CNT_W'(1);
                if (cmd.op == deq_pkg::OP_PUSH_F) begin
                  wr_idx    = deq_pkg::ring_add(front_r, deq_pkg::CNT_W'(deq_pkg::DEPTH - 1));
                  front_nxt = wr_idx;
                end else begin
                  wr_idx = deq_pkg::ring_add(front_r, count_r);
                end
              end
            end
            deq_pkg::OP_POP_F, deq_pkg::OP_POP_B: begin
              cmd_pop = 1'b1;
              if (count_r == '0) begin
                e_status = deq_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - deq_pkg::CNT_W'(1);
                if (cmd.op == deq_pkg::OP_POP_F) begin
                  rd_idx    = front_r;
                  front_nxt = deq_pkg::ring_add(front_r, deq_pkg::CNT_W'(1));
                end else begin
                  rd_idx = deq_pkg::ring_add(front_r, count_r - deq_pkg::CNT_W'(1));
                end
                e_value = store_r[rd_idx];
              end
            end
            deq_pkg::OP_LIST_F, deq_pkg::OP_LIST_B: begin
              if (count_r == '0) begin
                cmd_pop  = 1'b1;
                e_status = deq_pkg::ST_EMPTY;
              end else begin
                rd_idx  = deq_pkg::ring_add(front_r, list_off);
                e_value = store_r[rd_idx];
                if (list_done) begin
                  cmd_pop = 1'b1;
                end else begin
                  // hold the request and walk the rest of the entries
                  e_last    = 1'b0;
                  step_nxt  = step_r + deq_pkg::CNT_W'(1);
                  state_nxt = deq_pkg::BK_LIST;
                end
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      deq_pkg::BK_LIST: begin
        if (can_emit) begin
          emit    = 1'b1;
          rd_idx  = deq_pkg::ring_add(front_r, list_off);
          e_value = store_r[rd_idx];
          if (list_done) begin
            cmd_pop   = 1'b1;
            step_nxt  = '0;
            state_nxt = deq_pkg::BK_IDLE;
          end else begin
            e_last   = 1'b0;
            step_nxt = step_r + deq_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = deq_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::BK_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value_r     <= e_value;
      status_r    <= e_status;
      count_out_r <= deq_pkg::COUNT_W'(count_nxt);
      last_r      <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= cmd.value;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = value_r;
  assign out_status    = status_r;
  assign out_count_out = count_out_r;
  assign out_last      = last_r;

endmodule

// ===== rtl/core/double_ended_queue_unit.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque of signed 32-bit words held in a 16-entry ring buffer.
// ---------------------------------------------------------------------------
// Usage:
//   in_* channel carries one request: in_kind selects push front, push back,
//   pop front, pop back, list forward or list backward; in_value_in is the
//   word to push. out_* channel returns results: the popped or listed word,
//   a status (ok, empty, full), the entry count after the request and a
//   last flag on the final result of each request.
//   A request is accepted when in_valid is high and in_stall low; a result
//   is taken when out_valid is high and out_stall low.
//   A request passes through the command queue, then the result register.
//   Throughput: one request per cycle for pushes and pops while out_stall is
//   low; a list gives one result per cycle likewise, one per held entry or
//   a single empty result, and holds the back end until the last one.
//   A two-entry command queue decouples acceptance from execution, so new
//   requests are taken while a result waits at the output.
//   Reset empties the deque; stored words keep no reset value.
//   While out_stall is high and a result waits, the result holds and
//   execution pauses; in_stall rises once the command queue is full.
// ---------------------------------------------------------------------------
`include "double_ended_queue_unit_assert.svh"

module double_ended_queue_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [deq_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [deq_pkg::WORD_W-1:0]  in_value_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [deq_pkg::WORD_W-1:0]  out_value_out,
  output logic [deq_pkg::STATUS_W-1:0]       out_status,
  output logic [deq_pkg::COUNT_W-1:0]        out_count_out,
  output logic                               out_last
);

  logic          cmd_valid;
  deq_pkg::cmd_t cmd;
  logic          cmd_pop;

  deq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_value_in (in_value_in),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  deq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value_out (out_value_out),
    .out_status    (out_status),
    .out_count_out (out_count_out),
    .out_last      (out_last)
  );

  // a rejected push only happens at full occupancy
  `DEQ_ASSERT_IMP(a_full_count, out_valid && out_status == deq_pkg::ST_FULL, out_count_out == deq_pkg::COUNT_W'(deq_pkg::DEPTH) && out_value_out == '0 && out_last)
  `DEQ_ASSERT_IMP(a_empty_count, out_valid && out_status == deq_pkg::ST_EMPTY, out_count_out == '0 && out_value_out == '0 && out_last)
  // list results follow each other without gaps
  `DEQ_ASSERT_NXT(a_list_run, out_valid && !out_stall && !out_last, out_valid)
  `DEQ_ASSERT_IMP(a_stall_queue, !cmd_valid, !in_stall)

endmodule
